>>> rtl/gsppm_pkg.sv
package gsppm_pkg;

   localparam int MV_W      = 16;
   localparam int PPM_W     = 14;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 32;
   localparam int A_W       = 22;
   localparam int B_W       = 18;
   localparam int SEG_W     = 4;
   localparam int SEG_COUNT = 14;
   localparam int LOW_W     = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAN_AIR = 2'd1;

   localparam logic [MV_W-1:0] SUPPLY_RESET    = 16'd5000;
   localparam logic [MV_W-1:0] CLEAN_AIR_RESET = 16'd300;

   localparam logic [PPM_W-1:0] PPM_MAX = 14'd10000;

   // Division by ten of values below 2^18: multiply by ceil(2^22/10), keep bits 22 and up.
   localparam int DIV10_MUL_W = 19;
   localparam int DIV10_SHIFT = 22;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 19'd419431;

   // Ratio override codes.
   localparam logic [1:0] OVR_NONE  = 2'd0;
   localparam logic [1:0] OVR_LIMIT = 2'd1;
   localparam logic [1:0] OVR_ZERO  = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [1:0] ovr;
   } ctl_type;

   // Lower breakpoints in thousandths; a segment is taken when the ratio exceeds it.
   localparam logic [LOW_W-1:0] SEG_LOW [0:1][0:SEG_COUNT-1] = '{
      '{10'd1000, 10'd500, 10'd320, 10'd250, 10'd200, 10'd170, 10'd110,
        10'd87, 10'd72, 10'd65, 10'd52, 10'd43, 10'd0, 10'd0},
      '{10'd1000, 10'd250, 10'd170, 10'd140, 10'd115, 10'd95, 10'd80,
        10'd65, 10'd42, 10'd36, 10'd31, 10'd28, 10'd20, 10'd0}
   };

   // Slope magnitudes in tenths.
   localparam logic [A_W-1:0] SEG_A10 [0:1][0:SEG_COUNT-1] = '{
      '{22'd0, 22'd2000, 22'd5560, 22'd28600, 22'd40000, 22'd100000, 22'd166660,
        22'd435000, 22'd666660, 22'd1430000, 22'd1540000, 22'd3333330, 22'd0, 22'd0},
      '{22'd0, 22'd133, 22'd1240, 22'd3330, 22'd4000, 22'd5000, 22'd13330,
        22'd20000, 22'd43500, 22'd166660, 22'd200000, 22'd333330, 22'd625000, 22'd0}
   };

   // Intercepts in tenths.
   localparam logic [B_W-1:0] SEG_B10 [0:1][0:SEG_COUNT-1] = '{
      '{18'd1000, 18'd3000, 18'd4780, 18'd12150, 18'd15000, 18'd27000, 18'd38330,
        18'd67850, 18'd88000, 18'd143000, 18'd150000, 18'd243330, 18'd100000, 18'd100000},
      '{18'd0, 18'd133, 18'd410, 18'd770, 18'd860, 18'd980, 18'd1770,
        18'd2300, 18'd3820, 18'd9000, 18'd10200, 18'd14300, 18'd22500, 18'd0}
   };

   // Breakpoint in fixed point: floor(thousandths * 2^frac / 1000).
   function automatic logic [63:0] bp_calc(input logic [LOW_W-1:0] thou, input int frac);
      logic [63:0] scaled;
      scaled = 64'(thou) << frac;
      return scaled / 64'd1000;
   endfunction

endpackage

>>> rtl/gsppm_req_if.sv
interface gsppm_req_if;
   import gsppm_pkg::*;

   logic            valid;
   logic            ready;
   logic            kind;
   logic [MV_W-1:0] reading_mv;

   modport source (output valid, output kind, output reading_mv, input ready);
   modport sink   (input valid, input kind, input reading_mv, output ready);
endinterface

>>> rtl/gsppm_rsp_if.sv
interface gsppm_rsp_if;
   import gsppm_pkg::*;

   logic             valid;
   logic             ready;
   logic [PPM_W-1:0] ppm;

   modport source (output valid, output ppm, input ready);
   modport sink   (input valid, input ppm, output ready);
endinterface

>>> rtl/gsppm_csr_if.sv
interface gsppm_csr_if;
   import gsppm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [MV_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/gas_sensor_ppm_piecewise_convert_core.sv
// Path from an accepted request to a valid response: one product stage,
// RATIO_FRAC_BITS + 1 divider cells, four curve stages.
// Throughput: one transaction per cycle; each stage holds only while the one after it
// is full and stalled, so bubbles are squeezed out and the input keeps flowing.
// Reset: all stage valid bits clear at once, supply_mv returns to 5000 and
// clean_air_mv to 300; data registers are not reset.
module gas_sensor_ppm_piecewise_convert_core #(
   parameter int RATIO_FRAC_BITS = 20
) (
   input logic        clock,
   input logic        reset,
   gsppm_req_if.sink  req_chan,
   gsppm_rsp_if.source rsp_chan,
   gsppm_csr_if.sink  csr_chan
);
   import gsppm_pkg::*;

   localparam int CELLS = RATIO_FRAC_BITS + 1;

   logic [MV_W-1:0]   supply_ff;
   logic [MV_W-1:0]   clean_ff;

   ctl_type           s0_ctl_ff, s0_ctl_in;
   logic [PROD_W-1:0] s0_num_ff, s0_num_in;
   logic [PROD_W-1:0] s0_den_ff, s0_den_in;
   logic [MV_W-1:0]   supply_less_mv;
   logic [MV_W-1:0]   supply_less_clean;
   logic              s0_load;

   ctl_type                  cell_ctl   [0:CELLS];
   logic                     cell_ready [0:CELLS];
   logic [PROD_W:0]          cell_trial [0:CELLS-1];
   logic [PROD_W-1:0]        cell_den   [0:CELLS];
   logic [RATIO_FRAC_BITS:0] cell_quo   [0:CELLS];

   // Configuration writes are always taken; unknown indexes are ignored.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RESET;
         clean_ff  <= CLEAN_AIR_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SUPPLY:    supply_ff <= csr_chan.data;
            CSR_CLEAN_AIR: clean_ff  <= csr_chan.data;
            default:       ;
         endcase
      end
   end

   // Ratio = num / den with num = (supply - mv) * clean, den = mv * (supply - clean).
   always_comb begin
      supply_less_mv    = supply_ff - req_chan.reading_mv;
      supply_less_clean = supply_ff - clean_ff;
      s0_num_in         = PROD_W'(supply_less_mv) * PROD_W'(clean_ff);
      s0_den_in         = PROD_W'(req_chan.reading_mv) * PROD_W'(supply_less_clean);
      s0_ctl_in.valid   = req_chan.valid;
      s0_ctl_in.kind    = req_chan.kind;
      if (req_chan.reading_mv == '0 || clean_ff >= supply_ff) begin
         s0_ctl_in.ovr = OVR_LIMIT;
      end else if (req_chan.reading_mv >= supply_ff) begin
         s0_ctl_in.ovr = OVR_ZERO;
      end else begin
         s0_ctl_in.ovr = OVR_NONE;
      end
   end

   assign s0_load        = !s0_ctl_ff.valid || cell_ready[0];
   assign req_chan.ready = s0_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
      end else if (s0_load) begin
         s0_ctl_ff <= s0_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_num_ff <= s0_num_in;
         s0_den_ff <= s0_den_in;
      end
   end

   assign cell_ctl[0]   = s0_ctl_ff;
   assign cell_trial[0] = {1'b0, s0_num_ff};
   assign cell_den[0]   = s0_den_ff;
   assign cell_quo[0]   = '0;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      if (i < CELLS - 1) begin : g_mid
         gsppm_div_cell #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_ctl    (cell_ctl[i]),
            .in_ready  (cell_ready[i]),
            .in_trial  (cell_trial[i]),
            .in_den    (cell_den[i]),
            .in_quo    (cell_quo[i]),
            .out_ctl   (cell_ctl[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_trial (cell_trial[i+1]),
            .out_den   (cell_den[i+1]),
            .out_quo   (cell_quo[i+1])
         );
      end else begin : g_last
         gsppm_div_cell #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_ctl    (cell_ctl[i]),
            .in_ready  (cell_ready[i]),
            .in_trial  (cell_trial[i]),
            .in_den    (cell_den[i]),
            .in_quo    (cell_quo[i]),
            .out_ctl   (cell_ctl[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_trial (),
            .out_den   (cell_den[i+1]),
            .out_quo   (cell_quo[i+1])
         );
      end
   end

   gsppm_curve_eval #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_eval (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (cell_ctl[CELLS]),
      .in_quo    (cell_quo[CELLS]),
      .in_ready  (cell_ready[CELLS]),
      .out_valid (rsp_chan.valid),
      .out_ppm   (rsp_chan.ppm),
      .out_ready (rsp_chan.ready)
   );

   // A zero reading must be marked as the clamped ratio in the product stage.
   a_zero_reading_limit: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.reading_mv == '0
      |=> s0_ctl_ff.valid && s0_ctl_ff.ovr == OVR_LIMIT)
      else $error("zero reading not clamped to ratio limit");

   // Products held in the first stage must not change while the divider stalls.
   a_s0_hold: assert property (@(posedge clock) disable iff (reset)
      s0_ctl_ff.valid && !cell_ready[0]
      |=> $stable(s0_num_ff) && $stable(s0_den_ff) && $stable(s0_ctl_ff))
      else $error("first stage changed while stalled");

   // The saturation at the end of the curve stages bounds every result.
   a_ppm_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.ppm <= PPM_MAX)
      else $error("ppm above full scale");

   // Nothing is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !s0_ctl_ff.valid)
      else $error("pipeline not empty after reset");

endmodule

>>> rtl/gsppm_div_cell.sv
module gsppm_div_cell #(
   parameter int RATIO_FRAC_BITS = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gsppm_pkg::ctl_type                    in_ctl,
   output logic                                  in_ready,
   input  logic [gsppm_pkg::PROD_W:0]            in_trial,
   input  logic [gsppm_pkg::PROD_W-1:0]          in_den,
   input  logic [RATIO_FRAC_BITS:0]              in_quo,
   output gsppm_pkg::ctl_type                    out_ctl,
   input  logic                                  out_ready,
   output logic [gsppm_pkg::PROD_W:0]            out_trial,
   output logic [gsppm_pkg::PROD_W-1:0]          out_den,
   output logic [RATIO_FRAC_BITS:0]              out_quo
);
   import gsppm_pkg::*;

   ctl_type                  ctl_ff, ctl_in;
   logic [PROD_W-1:0]        rem_ff, rem_in;
   logic [PROD_W-1:0]        den_ff;
   logic [RATIO_FRAC_BITS:0] quo_ff, quo_in;
   logic [PROD_W:0]          diff;
   logic                     ge;
   logic                     over;
   logic                     load;

   assign load     = !ctl_ff.valid || out_ready;
   assign in_ready = load;

   // One restoring division step. A trial at or above twice the divisor first shows
   // in the integer step and means the ratio is at least 2.0.
   always_comb begin
      ge     = in_trial >= {1'b0, in_den};
      over   = in_trial >= {in_den, 1'b0};
      diff   = in_trial - {1'b0, in_den};
      rem_in = ge ? diff[PROD_W-1:0] : in_trial[PROD_W-1:0];
      quo_in = {in_quo[RATIO_FRAC_BITS-1:0], ge};
      ctl_in = in_ctl;
      if (in_ctl.ovr == OVR_NONE && over) begin
         ctl_in.ovr = OVR_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_trial = {rem_ff, 1'b0};
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;

endmodule

>>> rtl/gsppm_curve_eval.sv
module gsppm_curve_eval #(
   parameter int RATIO_FRAC_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gsppm_pkg::ctl_type            in_ctl,
   input  logic [RATIO_FRAC_BITS:0]      in_quo,
   output logic                          in_ready,
   output logic                          out_valid,
   output logic [gsppm_pkg::PPM_W-1:0]   out_ppm,
   input  logic                          out_ready
);
   import gsppm_pkg::*;

   localparam int RW   = RATIO_FRAC_BITS + 2;
   localparam int SUBW = RATIO_FRAC_BITS + A_W + 2;
   localparam int P10W = B_W + DIV10_MUL_W;
   localparam logic [RW-1:0] RATIO_LIMIT = {2'b10, {RATIO_FRAC_BITS{1'b0}}};

   logic [RW-1:0]      ratio;
   logic [SEG_COUNT-2:0] hit [0:1];
   logic [SEG_W-1:0]   seg;

   logic               e1_valid_ff, e2_valid_ff, e3_valid_ff, e4_valid_ff;
   logic               adv1, adv2, adv3, adv4;
   logic [RW-1:0]      e1_ratio_ff;
   logic [A_W-1:0]     e1_a10_ff, e1_a10_in;
   logic [B_W-1:0]     e1_b10_ff, e1_b10_in;
   logic [SUBW-1:0]    e2_sub_ff, e2_sub_in;
   logic [B_W-1:0]     e2_b10_ff;
   logic [B_W-1:0]     e3_val_ff, e3_val_in;
   logic [SUBW-1:0]    top;
   logic [SUBW-1:0]    line;
   logic [P10W-1:0]    tenth;
   logic [P10W-DIV10_SHIFT-1:0] quot;
   logic [PPM_W-1:0]   e4_ppm_ff, e4_ppm_in;

   assign adv4     = !e4_valid_ff || out_ready;
   assign adv3     = !e3_valid_ff || adv4;
   assign adv2     = !e2_valid_ff || adv3;
   assign adv1     = !e1_valid_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      case (in_ctl.ovr)
         OVR_NONE:  ratio = {1'b0, in_quo};
         OVR_LIMIT: ratio = RATIO_LIMIT;
         OVR_ZERO:  ratio = '0;
         default:   ratio = '0;
      endcase
   end

   // Breakpoint compares for both curves run side by side.
   for (genvar k = 0; k < 2; k++) begin : g_curve
      for (genvar i = 0; i < SEG_COUNT - 1; i++) begin : g_seg
         assign hit[k][i] = (SEG_LOW[k][i] == '0)
                          || (64'(ratio) > bp_calc(SEG_LOW[k][i], RATIO_FRAC_BITS));
      end
   end

   always_comb begin
      seg = SEG_W'(SEG_COUNT - 1);
      for (int i = SEG_COUNT - 2; i >= 0; i--) begin
         if (hit[in_ctl.kind][i]) begin
            seg = SEG_W'(i);
         end
      end
      e1_a10_in = SEG_A10[in_ctl.kind][seg];
      e1_b10_in = SEG_B10[in_ctl.kind][seg];
   end

   assign e2_sub_in = SUBW'(e1_a10_ff) * SUBW'(e1_ratio_ff);

   always_comb begin
      top  = SUBW'({e2_b10_ff, {RATIO_FRAC_BITS{1'b0}}});
      line = top - e2_sub_ff;
      if (e2_sub_ff >= top) begin
         e3_val_in = '0;
      end else begin
         e3_val_in = line[RATIO_FRAC_BITS +: B_W];
      end
   end

   always_comb begin
      tenth = P10W'(e3_val_ff) * P10W'(DIV10_MUL);
      quot  = tenth[P10W-1:DIV10_SHIFT];
      if (quot > (P10W-DIV10_SHIFT)'(PPM_MAX)) begin
         e4_ppm_in = PPM_MAX;
      end else begin
         e4_ppm_in = quot[PPM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
         e4_valid_ff <= 1'b0;
      end else begin
         if (adv1) e1_valid_ff <= in_ctl.valid;
         if (adv2) e2_valid_ff <= e1_valid_ff;
         if (adv3) e3_valid_ff <= e2_valid_ff;
         if (adv4) e4_valid_ff <= e3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         e1_ratio_ff <= ratio;
         e1_a10_ff   <= e1_a10_in;
         e1_b10_ff   <= e1_b10_in;
      end
      if (adv2) begin
         e2_sub_ff <= e2_sub_in;
         e2_b10_ff <= e1_b10_ff;
      end
      if (adv3) begin
         e3_val_ff <= e3_val_in;
      end
      if (adv4) begin
         e4_ppm_ff <= e4_ppm_in;
      end
   end

   assign out_valid = e4_valid_ff;
   assign out_ppm   = e4_ppm_ff;

endmodule
